### hdl/pvmt_pkg.sv
`default_nettype none
package pvmt_pkg;

	// Grid size of the surface; the store holds one entry per grid point.
	localparam int GRID_X = 64;
	localparam int GRID_Y = 64;
	localparam int DEPTH  = GRID_X * GRID_Y;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Field widths.
	localparam int COORD_W    = 6;
	localparam int VEL_W      = 24;
	localparam int SCALE_W    = 18;
	localparam int SCALE_FRAC = 16;
	localparam int MAG_W      = 25;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd65536;

	// Sum of squares, root and remainder widths of the square root unit.
	localparam int SQ_W   = 2 * MAG_W + 2;
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 4;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	// Stream data widths, rounded up to whole bytes.
	localparam int IN_BITS   = 2 * COORD_W + 3 * VEL_W;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 2 * MAG_W;
	localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Pair of peaks kept per grid point; horiz sits in the low bits.
	typedef struct packed {
		logic [MAG_W-1:0] total;
		logic [MAG_W-1:0] horiz;
	} pvmt_peaks_t;

	// Write request into the peak store.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		pvmt_peaks_t       data;
	} pvmt_mem_wr_t;

endpackage
`default_nettype wire

### hdl/pvmt_scale.sv
`default_nettype none
module pvmt_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [pvmt_pkg::VEL_W-1:0]    vel_x,
	input  logic [pvmt_pkg::VEL_W-1:0]    vel_y,
	input  logic [pvmt_pkg::VEL_W-1:0]    vel_z,
	input  logic [pvmt_pkg::SCALE_W-1:0]  scale,
	output logic                          out_valid,
	output logic [pvmt_pkg::SQ_W-1:0]     hsq,
	output logic [pvmt_pkg::SQ_W-1:0]     tsq
);
	import pvmt_pkg::*;

	localparam int PROD_W = VEL_W + SCALE_W;

	function automatic logic [VEL_W-1:0] abs_vel(input logic [VEL_W-1:0] v);
		return v[VEL_W-1] ? VEL_W'(~v + VEL_W'(1)) : v;
	endfunction

	logic [PROD_W-1:0]  prod_x, prod_y, prod_z;
	logic [MAG_W-1:0]   ax_s1, ay_s1, az_s1;
	logic [2*MAG_W-1:0] sqx_s2, sqy_s2, sqz_s2, sqz_s3;
	logic [SQ_W-1:0]    hsq_s3, hsq_s4, tsq_s4;
	logic               v_s1, v_s2, v_s3, v_s4;

	// Magnitude of each component times the scale.
	assign prod_x = abs_vel(vel_x) * scale;
	assign prod_y = abs_vel(vel_y) * scale;
	assign prod_z = abs_vel(vel_z) * scale;

	// Valid travels alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1 drops the fraction, stage 2 squares, stages 3 and 4 add.
	always_ff @(posedge clk) begin
		ax_s1  <= prod_x[SCALE_FRAC +: MAG_W];
		ay_s1  <= prod_y[SCALE_FRAC +: MAG_W];
		az_s1  <= prod_z[SCALE_FRAC +: MAG_W];
		sqx_s2 <= ax_s1 * ax_s1;
		sqy_s2 <= ay_s1 * ay_s1;
		sqz_s2 <= az_s1 * az_s1;
		hsq_s3 <= SQ_W'(sqx_s2) + SQ_W'(sqy_s2);
		sqz_s3 <= sqz_s2;
		hsq_s4 <= hsq_s3;
		tsq_s4 <= hsq_s3 + SQ_W'(sqz_s3);
	end

	assign out_valid = v_s4;
	assign hsq       = hsq_s4;
	assign tsq       = tsq_s4;

endmodule
`default_nettype wire

### hdl/pvmt_isqrt.sv
`default_nettype none
module pvmt_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pvmt_pkg::SQ_W-1:0]  radicand,
	output logic                       done,
	output logic [pvmt_pkg::MAG_W-1:0] root
);
	import pvmt_pkg::*;

	logic [SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q, rem_sh, trial;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic              take;

	// One root bit per cycle: bring down two radicand bits and try 4*root+1.
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(ROOT_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Radicand, partial remainder and partial root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// A root beyond the magnitude range saturates.
	assign root = root_q[ROOT_W-1] ? '1 : root_q[MAG_W-1:0];
	assign done = done_q;

endmodule
`default_nettype wire

### hdl/pvmt_peak_mem.sv
`default_nettype none
module pvmt_peak_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [pvmt_pkg::ADDR_W-1:0] rd_addr,
	output pvmt_pkg::pvmt_peaks_t       rd_data,
	input  pvmt_pkg::pvmt_mem_wr_t      wr,
	output logic                        clr_busy
);
	import pvmt_pkg::*;

	logic [MAG_W-1:0]  horiz_mem [DEPTH];
	logic [MAG_W-1:0]  total_mem [DEPTH];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;
	pvmt_peaks_t       rd_q;
	logic              we;
	logic [ADDR_W-1:0] wa;
	pvmt_peaks_t       wd;

	// Clearing pass after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// The clearing pass owns the write port while it runs.
	always_comb begin
		we = clr_busy_q | wr.en;
		wa = clr_busy_q ? clr_addr_q : wr.addr;
		wd = clr_busy_q ? '0 : wr.data;
	end

	// Both stores share one address; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			horiz_mem[wa] <= wd.horiz;
			total_mem[wa] <= wd.total;
		end
		if (rd_en) begin
			rd_q.horiz <= horiz_mem[rd_addr];
			rd_q.total <= total_mem[rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_busy_q;

endmodule
`default_nettype wire

### hdl/peak_velocity_magnitude_tracker_unit.sv
`default_nettype none
// Channel   Direction  tdata fields (lowest bit first)
// s_*       in         point_x[5:0] point_y[11:6] vel_x[35:12] vel_y[59:36] vel_z[83:60]
// m_*       out        peak_horizontal[24:0] peak_total[49:25]
// cfg_*     in         velocity_scale[17:0], written when cfg_wr_en is high
//
// Each accepted item passes through the scaling and squaring pipeline,
// loads the bit-serial square root units, runs through their root steps,
// enters write-back and is written back. The next item is accepted once the
// sequencer has returned to idle after the write-back. After reset every entry
// of the peak store is cleared, with s_tready low.
// A stalled result waits in the output register; only write-back waits on it.
module peak_velocity_magnitude_tracker_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pvmt_pkg::S_TDATA_W-1:0] s_tdata,   // point_x, point_y, vel_x, vel_y, vel_z
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pvmt_pkg::M_TDATA_W-1:0] m_tdata,   // peak_horizontal, peak_total
	input  logic                           cfg_wr_en,
	input  logic [pvmt_pkg::SCALE_W-1:0]   cfg_wr_data
);
	import pvmt_pkg::*;

	localparam int PY_LSB = COORD_W;
	localparam int VX_LSB = 2 * COORD_W;
	localparam int VY_LSB = VX_LSB + VEL_W;
	localparam int VZ_LSB = VY_LSB + VEL_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0]         state_q;
	logic [SCALE_W-1:0] scale_q;
	logic [ADDR_W-1:0]  addr_q, in_addr;
	logic               in_grid_q, in_grid;
	logic [COORD_W-1:0] in_px, in_py;
	logic               accept, clr_busy, write_go, out_free;
	logic               sq_valid, h_done, t_done;
	logic [SQ_W-1:0]    hsq, tsq;
	logic [MAG_W-1:0]   mag_h, mag_t;
	pvmt_peaks_t        rd_peaks, new_peaks, out_peaks_q;
	pvmt_mem_wr_t       wr;
	logic               out_valid_q;

	// Input decode and grid addressing.
	assign in_px    = s_tdata[0 +: COORD_W];
	assign in_py    = s_tdata[PY_LSB +: COORD_W];
	assign in_grid  = (int'(in_px) < GRID_X) && (int'(in_py) < GRID_Y);
	assign in_addr  = ADDR_W'(int'(in_py) * GRID_X + int'(in_px));
	assign s_tready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = s_tvalid && s_tready;

	// Scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	pvmt_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.vel_x     (s_tdata[VX_LSB +: VEL_W]),
		.vel_y     (s_tdata[VY_LSB +: VEL_W]),
		.vel_z     (s_tdata[VZ_LSB +: VEL_W]),
		.scale     (scale_q),
		.out_valid (sq_valid),
		.hsq       (hsq),
		.tsq       (tsq)
	);

	pvmt_isqrt u_isqrt_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_valid),
		.radicand (hsq),
		.done     (h_done),
		.root     (mag_h)
	);

	pvmt_isqrt u_isqrt_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_valid),
		.radicand (tsq),
		.done     (t_done),
		.root     (mag_t)
	);

	// The stored peaks are read as the item is accepted and held until write-back.
	pvmt_peak_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_addr),
		.rd_data  (rd_peaks),
		.wr       (wr),
		.clr_busy (clr_busy)
	);

	// Keep the address of the item at work.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q    <= in_addr;
			in_grid_q <= in_grid;
		end
	end

	// Sequencer: accept, compute, write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (h_done) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (write_go) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A peak is replaced only by a strictly larger magnitude.
	always_comb begin
		new_peaks.horiz = (rd_peaks.horiz < mag_h) ? mag_h : rd_peaks.horiz;
		new_peaks.total = (rd_peaks.total < mag_t) ? mag_t : rd_peaks.total;
		out_free        = !out_valid_q || m_tready;
		write_go        = (state_q == ST_WRITE) && out_free;
		wr.en           = write_go && in_grid_q;
		wr.addr         = addr_q;
		wr.data         = new_peaks;
	end

	// Output register; a point outside the grid returns zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_go) begin
			out_peaks_q <= in_grid_q ? new_peaks : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_peaks_q);

	// No item is taken while the store is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("item accepted during clearing pass");

	// Both roots start together and must finish together, while computing.
	a_roots_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		h_done |-> (t_done && (state_q == ST_CALC)))
		else $error("square root units out of step");

	// The total peak can never fall below the horizontal peak.
	a_total_ge_horiz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_peaks_q.total >= out_peaks_q.horiz))
		else $error("total peak below horizontal peak");

endmodule
`default_nettype wire

### tb/peak_velocity_magnitude_tracker_unit_test.sv
`timescale 1ns / 100ps

// One input item as it travels on s_tdata; px sits in the lowest bits.
typedef struct packed {
	logic [pvmt_pkg::VEL_W-1:0]   vz;
	logic [pvmt_pkg::VEL_W-1:0]   vy;
	logic [pvmt_pkg::VEL_W-1:0]   vx;
	logic [pvmt_pkg::COORD_W-1:0] py;
	logic [pvmt_pkg::COORD_W-1:0] px;
} sample_t;

// Tracks the peak magnitudes per grid point and checks each result against them.
class peak_scoreboard;
	logic [pvmt_pkg::MAG_W-1:0]   horiz_peak [pvmt_pkg::DEPTH];
	logic [pvmt_pkg::MAG_W-1:0]   total_peak [pvmt_pkg::DEPTH];
	logic [pvmt_pkg::SCALE_W-1:0] scale;
	pvmt_pkg::pvmt_peaks_t        peaks_q [$];
	int                           mismatches;

	function new();
		scale = pvmt_pkg::SCALE_RESET;
		mismatches = 0;
		foreach (horiz_peak[i]) begin
			horiz_peak[i] = '0;
			total_peak[i] = '0;
		end
	endfunction

	function void set_scale(logic [pvmt_pkg::SCALE_W-1:0] value);
		scale = value;
	endfunction

	// Absolute value of the component times the Q2.16 scale, truncated.
	function longint unsigned scaled_mag(logic [pvmt_pkg::VEL_W-1:0] v);
		longint unsigned mag;
		mag = v[pvmt_pkg::VEL_W-1] ? (64'd1 << pvmt_pkg::VEL_W) - 64'(v) : 64'(v);
		return (mag * 64'(scale)) >> pvmt_pkg::SCALE_FRAC;
	endfunction

	// Floor of the square root, built one bit at a time, then saturated.
	function logic [pvmt_pkg::MAG_W-1:0] root_sat(longint unsigned n);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		if (root > (64'd1 << pvmt_pkg::MAG_W) - 1)
			return '1;
		return root[pvmt_pkg::MAG_W-1:0];
	endfunction

	function void note_input(sample_t s);
		longint unsigned ax, ay, az, hsq, tsq;
		logic [pvmt_pkg::MAG_W-1:0] vh, vt;
		int addr;
		pvmt_pkg::pvmt_peaks_t p;
		ax = scaled_mag(s.vx);
		ay = scaled_mag(s.vy);
		az = scaled_mag(s.vz);
		hsq = ax * ax + ay * ay;
		tsq = hsq + az * az;
		vh = root_sat(hsq);
		vt = root_sat(tsq);
		p = '0;
		// A point outside the grid leaves the stores alone and reports zeros.
		if (int'(s.px) < pvmt_pkg::GRID_X && int'(s.py) < pvmt_pkg::GRID_Y) begin
			addr = int'(s.py) * pvmt_pkg::GRID_X + int'(s.px);
			if (vh > horiz_peak[addr])
				horiz_peak[addr] = vh;
			if (vt > total_peak[addr])
				total_peak[addr] = vt;
			p.horiz = horiz_peak[addr];
			p.total = total_peak[addr];
		end
		peaks_q.push_back(p);
	endfunction

	function void check_result(logic [pvmt_pkg::M_TDATA_W-1:0] d);
		pvmt_pkg::pvmt_peaks_t got, want;
		got = d[pvmt_pkg::OUT_BITS-1:0];
		if (peaks_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing outstanding: horiz %0d total %0d",
					$realtime, got.horiz, got.total);
			return;
		end
		want = peaks_q.pop_front();
		if (got.horiz !== want.horiz || got.total !== want.total) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: peak mismatch: horiz exp %0d got %0d, total exp %0d got %0d",
					$realtime, want.horiz, got.horiz, want.total, got.total);
		end
	endfunction

	function int pending();
		return peaks_q.size();
	endfunction
endclass

module peak_velocity_magnitude_tracker_unit_test;
	import pvmt_pkg::*;

	localparam int QUIET_LIMIT   = 20000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 100;
	localparam int HOLD_CYCLES   = 300;
	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

	typedef enum {
		TRAFFIC_STEADY,
		TRAFFIC_SENDER_IDLE,
		TRAFFIC_RECEIVER_STALL,
		TRAFFIC_BOTH
	} traffic_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_wr_en;
	logic [SCALE_W-1:0]   cfg_wr_data;

	peak_scoreboard peaks_sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [SCALE_W-1:0] scale_plan [RANDOM_PHASES] =
		'{SCALE_RESET, 18'd98304, 18'd0, SCALE_MAX, 18'd1, 18'd0, 18'd32768, 18'd0};

	peak_velocity_magnitude_tracker_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			peaks_sb.check_result(m_tdata);
	end

	// Ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL peak_velocity_magnitude_tracker_unit");
				$finish;
			end
		end
	end

	function automatic sample_t make_sample(int px, int py, int vx, int vy, int vz);
		sample_t s;
		s.px = COORD_W'(px);
		s.py = COORD_W'(py);
		s.vx = VEL_W'(vx);
		s.vy = VEL_W'(vy);
		s.vz = VEL_W'(vz);
		return s;
	endfunction

	// Mix of full-range, small, extreme and zero components.
	function automatic logic [VEL_W-1:0] random_vel();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return VEL_W'($urandom);
			5, 6, 7: return VEL_W'($urandom_range(2000)) - VEL_W'(1000);
			8: return $urandom_range(1) ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
			default: return '0;
		endcase
	endfunction

	// Most items hit a few hot points so that peaks get revisited often.
	function automatic sample_t random_sample();
		sample_t s;
		if ($urandom_range(99) < 60) begin
			s.px = COORD_W'($urandom_range(3));
			s.py = COORD_W'($urandom_range(3));
		end else begin
			s.px = COORD_W'($urandom_range(GRID_X - 1));
			s.py = COORD_W'($urandom_range(GRID_Y - 1));
		end
		s.vx = random_vel();
		s.vy = random_vel();
		s.vz = random_vel();
		return s;
	endfunction

	task automatic push_sample(sample_t s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = S_TDATA_W'(s);
		do @(posedge clk); while (!s_tready);
		peaks_sb.note_input(s);
	endtask

	// Stops offering items and waits until every result is back.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (peaks_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		peaks_sb.set_scale(value);
	endtask

	initial begin
		traffic_t mode;
		peaks_sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items at the reset scale: zero, extremes, strict peak update.
		push_sample(make_sample(0, 0, 0, 0, 0));
		push_sample(make_sample(0, 0, 1, 0, 0));
		push_sample(make_sample(0, 0, -8388608, -8388608, -8388608));
		push_sample(make_sample(0, 0, 100, -100, 5));
		push_sample(make_sample(63, 63, 8388607, 8388607, 8388607));
		push_sample(make_sample(63, 0, -1, 1, -1));
		push_sample(make_sample(0, 63, 0, 0, -8388608));
		push_sample(make_sample(5, 7, 3, 4, 0));
		push_sample(make_sample(5, 7, 4, -3, 0));
		push_sample(make_sample(5, 7, 0, 0, 12));
		push_sample(make_sample(5, 7, -2, 2, 2));

		// Largest scale: the first item drives both roots into saturation.
		write_scale(SCALE_MAX);
		push_sample(make_sample(1, 1, -8388608, -8388608, -8388608));
		push_sample(make_sample(1, 2, 8388607, 0, 0));
		push_sample(make_sample(1, 2, 0, 8388607, 0));

		// A zero scale leaves every peak where it was.
		write_scale('0);
		push_sample(make_sample(0, 0, 8388607, 8388607, 8388607));
		push_sample(make_sample(2, 2, -8388608, 123, -5));

		// The smallest nonzero scale truncates almost everything away.
		write_scale(18'd1);
		push_sample(make_sample(3, 3, -8388608, 8388607, 0));
		push_sample(make_sample(3, 3, 65535, 0, 0));

		// Random phases, each with its own scale and traffic pattern.
		scale_plan[2] = SCALE_W'($urandom);
		scale_plan[5] = SCALE_W'($urandom);
		scale_plan[7] = SCALE_W'($urandom_range(65536, 196608));
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_scale(scale_plan[phase]);
			mode = traffic_t'(phase % 4);
			case (mode)
				TRAFFIC_STEADY: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				TRAFFIC_SENDER_IDLE: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				TRAFFIC_RECEIVER_STALL: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			// Hold the receiver off while the sender keeps offering items.
			if (phase == 0)
				hold_request = 1;
			repeat (PHASE_ITEMS) push_sample(random_sample());
		end

		settle();
		if (peaks_sb.mismatches == 0 && peaks_sb.pending() == 0)
			$display("PASS peak_velocity_magnitude_tracker_unit");
		else
			$display("FAIL peak_velocity_magnitude_tracker_unit");
		$finish;
	end
endmodule
